FILE: sv/tmon_pkg.sv
`timescale 1ns / 1ps
package tmon_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [2:0] OP_CONFIGURE     = 3'd0;
    localparam logic [2:0] OP_SET_ENABLE    = 3'd1;
    localparam logic [2:0] OP_RECORD_RUN    = 3'd2;
    localparam logic [2:0] OP_RECORD_WAKE   = 3'd3;
    localparam logic [2:0] OP_RESET_METRICS = 3'd4;
    localparam logic [2:0] OP_READ_STATS    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNCONF  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        logic [31:0] deadline_lim;
        logic [31:0] period_len;
        logic        enable_flag;
        logic [62:0] start_us;
        logic [62:0] end_us;
        logic [62:0] due_us;
        logic [31:0] elapsed_ticks;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        enabled_out;
        logic [31:0] run_count;
        logic [31:0] overrun_count;
        logic [31:0] deadline_miss_count;
        logic [31:0] missed_period_count;
        logic [31:0] min_duration_us;
        logic [31:0] max_duration_us;
        logic [31:0] avg_duration_us;
        logic [31:0] last_duration_us;
        logic [31:0] peak_jitter_us;
    } result_t;

    // item as classified by the front end
    typedef struct packed {
        item_t item;
        logic  op_bad;
        logic  range_bad;
    } qent_t;

    typedef struct packed {
        logic        enabled;
        logic [31:0] deadline;
        logic [31:0] period;
        logic [31:0] runs;
        logic [31:0] overruns;
        logic [31:0] misses;
        logic [31:0] skipped_periods;
        logic [31:0] shortest;
        logic [31:0] longest;
        logic [63:0] duration_sum;
        logic [31:0] latest;
        logic [31:0] worst_jitter;
    } slot_rec_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_EXEC,
        BS_RUN2,
        BS_DIV,
        BS_DONE
    } back_state_t;

    function automatic slot_rec_t clear_metrics(slot_rec_t r);
        slot_rec_t c;
        c = r;
        c.runs            = '0;
        c.overruns        = '0;
        c.misses          = '0;
        c.skipped_periods = '0;
        c.shortest        = '1;
        c.longest         = '0;
        c.duration_sum    = '0;
        c.latest          = '0;
        c.worst_jitter    = '0;
        return c;
    endfunction

endpackage

FILE: sv/tmon_ifs.sv
`timescale 1ns / 1ps
interface tmon_req_if;
    logic            valid;
    logic            ready;
    tmon_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmon_rsp_if;
    logic              valid;
    logic              ready;
    tmon_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/tmon_ram.sv
`timescale 1ns / 1ps
module tmon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/tmon_div.sv
`timescale 1ns / 1ps
module tmon_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import tmon_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;

    logic [32:0] r1, r2;
    logic        ge1, ge2;
    logic [31:0] r1s;

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, quo_reg[63]};
        ge1 = r1 >= {1'b0, dvs_reg};
        r1s = ge1 ? 32'(r1 - {1'b0, dvs_reg}) : r1[31:0];
        r2  = {r1s, quo_reg[62]};
        ge2 = r2 >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge2 ? 32'(r2 - {1'b0, dvs_reg}) : r2[31:0];
            quo_next = {quo_reg[61:0], ge1, ge2};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: sv/tmon_front.sv
`timescale 1ns / 1ps
module tmon_front #(
    parameter int NUM_SLOTS = tmon_pkg::NUM_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    tmon_req_if.sink        req,
    output tmon_pkg::qent_t q_data,
    output logic            q_valid,
    input  logic            q_ready
);
    import tmon_pkg::*;

    localparam int QD = 2;

    qent_t      ent_reg [QD];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    qent_t      cls;
    logic       push, pop;

    always_comb
    begin
        cls.item      = req.data;
        cls.op_bad    = req.data.opcode > OP_READ_STATS;
        cls.range_bad = 32'(req.data.slot) >= NUM_SLOTS;
    end

    assign req.ready = cnt_reg != 2'(QD);
    assign push      = req.valid && req.ready;
    assign q_valid   = cnt_reg != '0;
    assign pop       = q_valid && q_ready;
    assign q_data    = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: sv/tmon_back.sv
`timescale 1ns / 1ps
module tmon_back #(
    parameter int NUM_SLOTS = tmon_pkg::NUM_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tmon_pkg::qent_t q_data,
    input  logic            q_valid,
    output logic            q_ready,
    tmon_rsp_if.source      rsp
);
    import tmon_pkg::*;

    localparam int SAW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RW  = $bits(slot_rec_t);

    back_state_t state_reg, state_next;
    qent_t       cur_reg, cur_next;
    slot_rec_t   rec_reg, rec_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [NUM_SLOTS-1:0] cfg_reg, cfg_next;
    logic [31:0] dur_reg, dur_next;
    logic [62:0] jit_reg, jit_next;
    logic [63:0] expdl_reg, expdl_next;

    logic [SAW-1:0] slot_idx;
    logic           ram_we;
    slot_rec_t      wrec;
    logic [RW-1:0]  ram_rdata;
    logic           div_start, div_done;
    logic [63:0]    div_dividend, div_quo;
    logic [31:0]    div_divisor;
    logic           wake_go;

    assign slot_idx = SAW'(cur_reg.item.slot);
    assign wake_go  = (rec_reg.period != '0) && (cur_reg.item.elapsed_ticks > rec_reg.period);
    assign div_dividend = (cur_reg.item.opcode == OP_RECORD_WAKE) ?
                          {32'd0, cur_reg.item.elapsed_ticks} : rec_reg.duration_sum;
    assign div_divisor  = (cur_reg.item.opcode == OP_RECORD_WAKE) ?
                          rec_reg.period : rec_reg.runs;

    tmon_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (wrec),
        .raddr (SAW'(q_data.item.slot)),
        .rdata (ram_rdata)
    );

    tmon_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_data.op_bad || q_data.range_bad) ? BS_DONE : BS_READ;
                end
            end
            BS_READ:
            begin
                if (cur_reg.item.opcode != OP_CONFIGURE && !cfg_reg[slot_idx])
                begin
                    state_next = BS_DONE;
                end
                else
                begin
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                state_next = BS_DONE;
                if (cur_reg.item.opcode == OP_RECORD_RUN && rec_reg.enabled)
                begin
                    state_next = BS_RUN2;
                end
                else if (cur_reg.item.opcode == OP_RECORD_WAKE && wake_go)
                begin
                    state_next = BS_DIV;
                end
                else if (cur_reg.item.opcode == OP_READ_STATS && rec_reg.runs != '0)
                begin
                    state_next = BS_DIV;
                end
            end
            BS_RUN2: state_next = BS_DONE;
            BS_DIV:  state_next = div_done ? BS_DONE : BS_DIV;
            BS_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_next       = cur_reg;
        rec_next       = rec_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cfg_next       = cfg_reg;
        dur_next       = dur_reg;
        jit_next       = jit_reg;
        expdl_next     = expdl_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        wrec           = rec_reg;
        div_start      = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BS_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_next = q_data;
                    res_next = '0;
                    if (!q_data.op_bad && q_data.range_bad)
                    begin
                        res_next.status = ST_RANGE;
                    end
                end
            end
            BS_READ:
            begin
                rec_next = ram_rdata;
                if (cur_reg.item.opcode != OP_CONFIGURE && !cfg_reg[slot_idx])
                begin
                    res_next.status = ST_UNCONF;
                end
            end
            BS_EXEC:
            begin
                unique case (cur_reg.item.opcode)
                    OP_CONFIGURE:
                    begin
                        wrec          = clear_metrics(rec_reg);
                        wrec.deadline = cur_reg.item.deadline_lim;
                        wrec.period   = cur_reg.item.period_len;
                        wrec.enabled  = cur_reg.item.enable_flag;
                        ram_we        = 1'b1;
                        cfg_next[slot_idx] = 1'b1;
                    end
                    OP_SET_ENABLE:
                    begin
                        wrec.enabled = cur_reg.item.enable_flag;
                        ram_we       = 1'b1;
                    end
                    OP_RECORD_RUN:
                    begin
                        dur_next = 32'(cur_reg.item.end_us - cur_reg.item.start_us);
                        jit_next = (cur_reg.item.start_us >= cur_reg.item.due_us) ?
                                   cur_reg.item.start_us - cur_reg.item.due_us :
                                   cur_reg.item.due_us - cur_reg.item.start_us;
                        expdl_next = {1'b0, cur_reg.item.due_us} +
                                     {32'd0, rec_reg.deadline};
                    end
                    OP_RECORD_WAKE:
                    begin
                        div_start = wake_go;
                    end
                    OP_RESET_METRICS:
                    begin
                        wrec   = clear_metrics(rec_reg);
                        ram_we = 1'b1;
                    end
                    OP_READ_STATS:
                    begin
                        res_next.enabled_out         = rec_reg.enabled;
                        res_next.run_count           = rec_reg.runs;
                        res_next.overrun_count       = rec_reg.overruns;
                        res_next.deadline_miss_count = rec_reg.misses;
                        res_next.missed_period_count = rec_reg.skipped_periods;
                        res_next.min_duration_us     = (rec_reg.shortest == '1) ?
                                                       '0 : rec_reg.shortest;
                        res_next.max_duration_us     = rec_reg.longest;
                        res_next.last_duration_us    = rec_reg.latest;
                        res_next.peak_jitter_us      = rec_reg.worst_jitter;
                        div_start = rec_reg.runs != '0;
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            BS_RUN2:
            begin
                if ({1'b0, jit_reg} > {32'd0, rec_reg.worst_jitter})
                begin
                    wrec.worst_jitter = jit_reg[31:0];
                end
                wrec.runs         = rec_reg.runs + 32'd1;
                wrec.latest       = dur_reg;
                wrec.duration_sum = rec_reg.duration_sum + {32'd0, dur_reg};
                if (dur_reg < rec_reg.shortest)
                begin
                    wrec.shortest = dur_reg;
                end
                if (dur_reg > rec_reg.longest)
                begin
                    wrec.longest = dur_reg;
                end
                if (rec_reg.deadline != '0)
                begin
                    if (dur_reg > rec_reg.deadline)
                    begin
                        wrec.overruns = rec_reg.overruns + 32'd1;
                    end
                    if ({1'b0, cur_reg.item.end_us} > expdl_reg)
                    begin
                        wrec.misses = rec_reg.misses + 32'd1;
                    end
                end
                ram_we = 1'b1;
            end
            BS_DIV:
            begin
                if (div_done)
                begin
                    if (cur_reg.item.opcode == OP_RECORD_WAKE)
                    begin
                        wrec.skipped_periods = rec_reg.skipped_periods + div_quo[31:0];
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        res_next.avg_duration_us = div_quo[31:0];
                    end
                end
            end
            BS_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        rec_reg   <= rec_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        dur_reg   <= dur_next;
        jit_reg   <= jit_next;
        expdl_reg <= expdl_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;
endmodule

FILE: sv/task_timing_monitor.sv
`timescale 1ns / 1ps
// sequence: the back end takes an item from the queue in idle, then steps through read,
// exec and done; a run on an enabled slot adds run2, a bad opcode or slot goes from idle
// straight to done, and an unconfigured slot goes from read to done; record_wake with a
// missed period and read_stats with runs wait in div for the 2-bit-per-cycle 64/32 divider
// the back end handles one item at a time and holds it in done while the result is stalled
// reset: rst_n asynchronous active low; all slots unconfigured, queue and result empty
module task_timing_monitor #(
    parameter int NUM_SLOTS = tmon_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tmon_req_if.sink   req,
    tmon_rsp_if.source rsp
);
    import tmon_pkg::*;

    // classified items waiting for the back end
    qent_t q_data;
    logic  q_valid;
    logic  q_ready;

    // front end: accepts items, flags bad opcodes and out of range slots,
    // and buffers them in a two-entry queue
    tmon_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // back end: read-modify-write of the slot table in ram, divider for
    // the average and missed periods, result register toward the sink
    tmon_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .rsp     (rsp)
    );
endmodule

FILE: sv/tmon_chk.sv
`timescale 1ns / 1ps
module tmon_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input tmon_pkg::result_t rsp_data
);
    import tmon_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status != ST_INVALID)
        else $error("illegal status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |->
            rsp_data.run_count == '0 && rsp_data.avg_duration_us == '0 &&
            !rsp_data.enabled_out)
        else $error("failed item carries data");

    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.run_count != '0 |->
            rsp_data.min_duration_us <= rsp_data.max_duration_us)
        else $error("min above max");
endmodule

bind task_timing_monitor tmon_chk u_tmon_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

FILE: bench/tmon_checker.sv
`timescale 1ns / 1ps
module tmon_checker (
    input  logic     clk,
    input  logic     rst_n,
    tmon_req_if.sink watch_req,
    tmon_rsp_if.sink watch_rsp,
    output int       fail_count,
    output int       pending_count,
    output int       result_count
);
    import tmon_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    // per-slot statistics table
    logic        t_conf [SLOTS];
    logic        t_en [SLOTS];
    logic [31:0] t_dl [SLOTS];
    logic [31:0] t_per [SLOTS];
    logic [31:0] t_runs [SLOTS];
    logic [31:0] t_over [SLOTS];
    logic [31:0] t_miss [SLOTS];
    logic [31:0] t_mp [SLOTS];
    logic [31:0] t_short [SLOTS];
    logic [31:0] t_long [SLOTS];
    logic [63:0] t_sum [SLOTS];
    logic [31:0] t_last [SLOTS];
    logic [31:0] t_jit [SLOTS];

    result_t expected_results[$];

    function automatic void clear_slot(int s);
        t_runs[s] = '0;
        t_over[s] = '0;
        t_miss[s] = '0;
        t_mp[s] = '0;
        t_short[s] = '1;
        t_long[s] = '0;
        t_sum[s] = '0;
        t_last[s] = '0;
        t_jit[s] = '0;
    endfunction

    function automatic result_t predict_stats(item_t it);
        result_t r;
        int s;
        logic [63:0] jit;
        logic [31:0] dur;
        logic [64:0] due;
        r = '0;
        s = it.slot;
        if (it.opcode > OP_READ_STATS)
            return r;
        if (s >= SLOTS)
        begin
            r.status = ST_RANGE;
            return r;
        end
        if (it.opcode != OP_CONFIGURE && !t_conf[s])
        begin
            r.status = ST_UNCONF;
            return r;
        end
        r.status = ST_OK;
        case (it.opcode)
            OP_CONFIGURE:
            begin
                clear_slot(s);
                t_conf[s] = 1'b1;
                t_dl[s] = it.deadline_lim;
                t_per[s] = it.period_len;
                t_en[s] = it.enable_flag;
            end
            OP_SET_ENABLE: t_en[s] = it.enable_flag;
            OP_RECORD_RUN:
                if (t_en[s])
                begin
                    dur = 32'({1'b0, it.end_us} - {1'b0, it.start_us});
                    jit = (it.start_us >= it.due_us) ? 64'(it.start_us - it.due_us)
                                                      : 64'(it.due_us - it.start_us);
                    if (jit > {32'd0, t_jit[s]})
                        t_jit[s] = jit[31:0];
                    t_runs[s] += 1;
                    t_last[s] = dur;
                    t_sum[s] += {32'd0, dur};
                    if (dur < t_short[s])
                        t_short[s] = dur;
                    if (dur > t_long[s])
                        t_long[s] = dur;
                    if (t_dl[s] != 0)
                    begin
                        if (dur > t_dl[s])
                            t_over[s] += 1;
                        due = {2'b0, it.due_us} + {33'd0, t_dl[s]};
                        if ({2'b0, it.end_us} > due)
                            t_miss[s] += 1;
                    end
                end
            OP_RECORD_WAKE:
                if (t_per[s] != 0 && it.elapsed_ticks > t_per[s])
                    t_mp[s] += it.elapsed_ticks / t_per[s];
            OP_RESET_METRICS: clear_slot(s);
            default:
            begin
                r.enabled_out = t_en[s];
                r.run_count = t_runs[s];
                r.overrun_count = t_over[s];
                r.deadline_miss_count = t_miss[s];
                r.missed_period_count = t_mp[s];
                r.min_duration_us = (t_short[s] == '1) ? '0 : t_short[s];
                r.max_duration_us = t_long[s];
                r.avg_duration_us = (t_runs[s] != 0) ? 32'(t_sum[s] / {32'd0, t_runs[s]}) : '0;
                r.last_duration_us = t_last[s];
                r.peak_jitter_us = t_jit[s];
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, what, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e, a;
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                t_conf[s] = 0;
                t_en[s] = 0;
                t_dl[s] = 0;
                t_per[s] = 0;
                clear_slot(s);
            end
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (watch_req.valid && watch_req.ready)
                expected_results.push_back(predict_stats(watch_req.data));
            if (watch_rsp.valid && watch_rsp.ready)
            begin
                a = watch_rsp.data;
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result %0h", $time, a);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    report("status", 32'(e.status), 32'(a.status));
                    report("enabled", 32'(e.enabled_out), 32'(a.enabled_out));
                    report("run_count", e.run_count, a.run_count);
                    report("overruns", e.overrun_count, a.overrun_count);
                    report("misses", e.deadline_miss_count, a.deadline_miss_count);
                    report("skipped periods", e.missed_period_count, a.missed_period_count);
                    report("min", e.min_duration_us, a.min_duration_us);
                    report("max", e.max_duration_us, a.max_duration_us);
                    report("avg", e.avg_duration_us, a.avg_duration_us);
                    report("last", e.last_duration_us, a.last_duration_us);
                    report("jitter", e.peak_jitter_us, a.peak_jitter_us);
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tmon_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   idle_cycles;
    int   send_idle;    // percent chance the sender holds off
    int   recv_stall;   // percent chance the receiver stalls
    int   sent_items;
    bit   timed_out;

    tmon_req_if req ();
    tmon_rsp_if rsp ();

    task_timing_monitor uut (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    tmon_checker checker_i (
        .clk(clk), .rst_n(rst_n), .watch_req(req.sink), .watch_rsp(rsp.sink),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls at the current pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // mostly short timestamps so durations and deadlines interact;
    // occasionally the full range to hit the wrap and carry paths
    function automatic logic [62:0] rand_stamp(logic [62:0] base);
        case ($urandom_range(9))
            0: return rand63();
            1: return '1;
            2: return '0;
            default: return base + 63'($urandom_range(3000));
        endcase
    endfunction

    // one item on the request channel, with optional hold-off before it;
    // ready only changes at the rising edge, so its value at the falling edge
    // is the one the next rising edge sees
    task automatic send_item(item_t it);
        logic took;
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= it;
        do
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
        while (!took);
        sent_items++;
    endtask

    task automatic drop_valid();
        req.valid <= 1'b0;
    endtask

    function automatic item_t random_item();
        item_t it;
        logic [62:0] base;
        it.opcode = 3'($urandom_range(99) < 3 ? 6 + $urandom_range(1) : 0);
        case ($urandom_range(19))
            0, 1:    it.opcode = OP_CONFIGURE;
            2:       it.opcode = OP_SET_ENABLE;
            3:       it.opcode = OP_RESET_METRICS;
            4, 5, 6: it.opcode = OP_RECORD_WAKE;
            7, 8, 9: it.opcode = OP_READ_STATS;
            19:      it.opcode = ($urandom_range(1) != 0) ? 3'd6 : 3'd7;
            default: it.opcode = OP_RECORD_RUN;
        endcase
        // slots 0..11 get used, 12..15 are touched rarely so unconfigured cases stay
        it.slot = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
        it.deadline_lim = ($urandom_range(7) == 0) ? $urandom()
                         : ($urandom_range(4) == 0 ? 32'd0 : 32'($urandom_range(2500)));
        it.period_len = ($urandom_range(7) == 0) ? $urandom()
                       : ($urandom_range(9) == 0 ? 32'd0 : 32'($urandom_range(1, 200)));
        it.enable_flag = ($urandom_range(4) != 0);
        base = ($urandom_range(3) == 0) ? rand63() : 63'($urandom());
        it.due_us = rand_stamp(base);
        it.start_us = rand_stamp(base);
        it.end_us = rand_stamp(it.start_us);
        it.elapsed_ticks = ($urandom_range(5) == 0) ? $urandom() : 32'($urandom_range(1000));
        return it;
    endfunction

    task automatic wait_drained();
        drop_valid();
        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        send_idle = 0;
        recv_stall = 0;
        sent_items = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unconfigured slot, configure extremes, each opcode, edge timestamps
        it = '0;
        it.opcode = OP_READ_STATS;   it.slot = 4'd15; send_item(it);
        it.opcode = OP_RECORD_RUN;   send_item(it);
        it.opcode = OP_CONFIGURE; it.slot = 4'd15; it.deadline_lim = '1;
        it.period_len = '1; it.enable_flag = 1'b1; send_item(it);
        it.opcode = OP_CONFIGURE; it.slot = 4'd0; it.deadline_lim = 32'd100;
        it.period_len = 32'd0; send_item(it);
        it.opcode = OP_RECORD_WAKE; it.elapsed_ticks = '1; send_item(it);
        it.opcode = OP_RECORD_RUN; it.start_us = '1; it.end_us = '0;
        it.due_us = '0; send_item(it);
        it.start_us = '0; it.end_us = '1; it.due_us = '1; send_item(it);
        it.start_us = 63'd50; it.end_us = 63'd250; it.due_us = 63'd10; send_item(it);
        it.opcode = OP_READ_STATS; send_item(it);
        it.opcode = OP_SET_ENABLE; it.enable_flag = 1'b0; send_item(it);
        it.opcode = OP_RECORD_RUN; send_item(it);
        it.opcode = OP_READ_STATS; send_item(it);
        it.opcode = OP_CONFIGURE; it.slot = 4'd1; it.period_len = 32'd7;
        it.enable_flag = 1'b1; send_item(it);
        it.opcode = OP_RECORD_WAKE; it.elapsed_ticks = 32'd7; send_item(it);
        it.elapsed_ticks = 32'd50; send_item(it);
        it.elapsed_ticks = '1; send_item(it);
        it.opcode = OP_READ_STATS; send_item(it);
        it.opcode = OP_RESET_METRICS; send_item(it);
        it.opcode = OP_READ_STATS; send_item(it);
        it.opcode = 3'd6; send_item(it);
        it.opcode = 3'd7; send_item(it);
        it.opcode = OP_READ_STATS; it.slot = 4'd15; send_item(it);
        // sender pauses until every expected result is back
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            for (int n = 0; n < 500; n++)
                send_item(random_item());
        end
        wait_drained();

        $display("sent %0d items over four idle/stall phases, %0d results checked",
                 sent_items, result_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
